FILE: src/hse_pkg.sv
// Shared types and sizing constants for the heap sort engine.
package hse_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int CHILD_W     = IDX_W + 2;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] sorted_value;
      logic                          final_res;
      logic                          overflowed;
   } rsp_type;

endpackage

FILE: src/heap_sort_engine.sv
// Heap sort engine: collects a set of signed values, sorts it with a max-heap and emits it.
//
// Values arrive one beat at a time and are written into a 64-entry single-port-read,
// single-port-write RAM; a beat with last set closes the set. Beats beyond 64 are dropped
// and every result of that set then carries overflowed. While sorting and emitting, the
// input is stalled. The heap is built and then drained in place in the same RAM: each
// level of a sift-down reads the left child, reads the right child, then compares and
// writes back, and each sift adds setup reads and a final write of the sifted value.
// Sorting speed is bounded by the one RAM read port. Results then leave one at a time:
// each is read from the RAM and held until the receiver takes it before the next is
// read.
module heap_sort_engine
   import hse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [3:0] S_LOAD      = 4'd0;
   localparam logic [3:0] S_BLD_RD    = 4'd1;
   localparam logic [3:0] S_BLD_LD    = 4'd2;
   localparam logic [3:0] S_SIFT_L    = 4'd3;
   localparam logic [3:0] S_SIFT_R    = 4'd4;
   localparam logic [3:0] S_SIFT_C    = 4'd5;
   localparam logic [3:0] S_SIFT_END  = 4'd6;
   localparam logic [3:0] S_EXT_RD0   = 4'd7;
   localparam logic [3:0] S_EXT_RD1   = 4'd8;
   localparam logic [3:0] S_EXT_WR    = 4'd9;
   localparam logic [3:0] S_EMIT_RD   = 4'd10;
   localparam logic [3:0] S_EMIT_LD   = 4'd11;
   localparam logic [3:0] S_EMIT_WAIT = 4'd12;

   logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];

   logic [3:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          dropped_ff, dropped_in;
   logic [CNT_W-1:0]              size_ff, size_in;
   logic [IDX_W-1:0]              root_ff, root_in;
   logic [IDX_W-1:0]              node_ff, node_in;
   logic [IDX_W-1:0]              emit_ff, emit_in;
   logic                          building_ff, building_in;
   logic                          rc_ok_ff, rc_ok_in;
   logic signed [VALUE_WIDTH-1:0] node_val_ff, node_val_in;
   logic signed [VALUE_WIDTH-1:0] lc_val_ff, lc_val_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_ff, rsp_in;

   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]              rd_addr;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;

   logic [CHILD_W-1:0]            lc, rc, size_ext;
   logic [CNT_W-1:0]              n_eff;
   logic                          store_ok;
   logic [IDX_W-1:0]              top;
   logic signed [VALUE_WIDTH-1:0] top_val;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign lc       = {1'b0, node_ff, 1'b1};
   assign rc       = lc + CHILD_W'(1);
   assign size_ext = CHILD_W'(size_ff);
   assign store_ok = (count_ff < CNT_W'(CAPACITY));
   assign n_eff    = store_ok ? count_ff + CNT_W'(1) : count_ff;

   // Larger of the node and its children; the left child wins a tie with the right.
   always_comb begin
      top     = node_ff;
      top_val = node_val_ff;
      if (lc_val_ff > top_val) begin
         top     = lc[IDX_W-1:0];
         top_val = lc_val_ff;
      end
      if (rc_ok_ff && (rd_data_ff > top_val)) begin
         top     = rc[IDX_W-1:0];
         top_val = rd_data_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      size_in      = size_ff;
      root_in      = root_ff;
      node_in      = node_ff;
      emit_in      = emit_ff;
      building_in  = building_ff;
      rc_ok_in     = rc_ok_ff;
      node_val_in  = node_val_ff;
      lc_val_in    = lc_val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_addr      = node_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = node_val_ff;
      req_stall    = 1'b1;

      case (state_ff)
         S_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (store_ok) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  wr_data  = req_data.value;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.last) begin
                  size_in     = n_eff;
                  root_in     = IDX_W'((n_eff >> 1) - CNT_W'(1));
                  building_in = 1'b1;
                  emit_in     = '0;
                  state_in    = (n_eff > CNT_W'(1)) ? S_BLD_RD : S_EMIT_RD;
               end
            end
         end
         S_BLD_RD: begin
            rd_addr  = root_ff;
            state_in = S_BLD_LD;
         end
         S_BLD_LD: begin
            node_val_in = rd_data_ff;
            node_in     = root_ff;
            state_in    = S_SIFT_L;
         end
         S_SIFT_L: begin
            rd_addr = lc[IDX_W-1:0];
            if (lc >= size_ext) begin
               state_in = S_SIFT_END;
            end else begin
               state_in = S_SIFT_R;
            end
         end
         S_SIFT_R: begin
            lc_val_in = rd_data_ff;
            rd_addr   = rc[IDX_W-1:0];
            rc_ok_in  = (rc < size_ext);
            state_in  = S_SIFT_C;
         end
         S_SIFT_C: begin
            if (top == node_ff) begin
               state_in = S_SIFT_END;
            end else begin
               // The larger child moves up; the sifted value is written once it settles.
               wr_en    = 1'b1;
               wr_addr  = node_ff;
               wr_data  = top_val;
               node_in  = top;
               state_in = S_SIFT_L;
            end
         end
         S_SIFT_END: begin
            wr_en   = 1'b1;
            wr_addr = node_ff;
            wr_data = node_val_ff;
            if (building_ff) begin
               if (root_ff == '0) begin
                  building_in = 1'b0;
                  size_in     = count_ff - CNT_W'(1);
                  state_in    = S_EXT_RD0;
               end else begin
                  root_in  = root_ff - IDX_W'(1);
                  state_in = S_BLD_RD;
               end
            end else if (size_ff == CNT_W'(1)) begin
               emit_in  = '0;
               state_in = S_EMIT_RD;
            end else begin
               size_in  = size_ff - CNT_W'(1);
               state_in = S_EXT_RD0;
            end
         end
         S_EXT_RD0: begin
            rd_addr  = size_ff[IDX_W-1:0];
            state_in = S_EXT_RD1;
         end
         S_EXT_RD1: begin
            node_val_in = rd_data_ff;
            rd_addr     = '0;
            state_in    = S_EXT_WR;
         end
         S_EXT_WR: begin
            // Old root goes to the end; the old end value sifts down from the root.
            wr_en    = 1'b1;
            wr_addr  = size_ff[IDX_W-1:0];
            wr_data  = rd_data_ff;
            node_in  = '0;
            state_in = S_SIFT_L;
         end
         S_EMIT_RD: begin
            rd_addr  = emit_ff;
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            rsp_valid_in        = 1'b1;
            rsp_in.sorted_value = rd_data_ff;
            rsp_in.final_res    = (CNT_W'(emit_ff) + CNT_W'(1) == count_ff);
            rsp_in.overflowed   = dropped_ff;
            state_in            = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.final_res) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_LOAD;
               end else begin
                  emit_in  = emit_ff + IDX_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         building_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         building_ff  <= building_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      root_ff     <= root_in;
      node_ff     <= node_in;
      emit_ff     <= emit_in;
      rc_ok_ff    <= rc_ok_in;
      node_val_ff <= node_val_in;
      lc_val_ff   <= lc_val_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: tb/sv/heap_sort_engine_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for heap_sort_engine: random sets, random idling, sorted-order check.
module heap_sort_engine_tb;
   import hse_pkg::*;

   localparam int CYCLE_LIMIT = 400_000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   heap_sort_engine uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   req_type pending_items [$];
   rsp_type sorted_expect [$];

   // Model of the set being collected.
   logic signed [VALUE_WIDTH-1:0] held_values [CAPACITY];
   int held_count   = 0;
   bit held_dropped = 1'b0;

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   int  hold_left      = 0;
   bit  req_taken      = 1'b0;
   int  cycle_count    = 0;
   int  items_accepted = 0;
   int  results_checked = 0;
   int  sets_closed    = 0;
   int  overflow_sets  = 0;
   int  mismatch_count = 0;

   logic signed [VALUE_WIDTH-1:0] directed_values [20] = '{
      32'sh8000_0000,
      32'sh7fff_ffff,
      32'sh0000_0000, 32'shffff_ffff,
      32'sh7fff_ffff, 32'sh0000_0001, 32'sh0000_0000, 32'shffff_ffff, 32'sh8000_0000,
      32'sh0000_0005, 32'sh0000_0005, 32'shffff_fffd, 32'sh0000_0005, 32'shffff_fffd,
      32'sh0000_0000,
      32'sh8000_0000, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh7fff_fffe, 32'sh7fff_ffff
   };
   bit directed_last [20] = '{1, 1, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1};

   // Restores the max-heap property below node within the first heap_size entries.
   function automatic void sift_heap(int heap_size, int node);
      int top;
      bit moving;
      logic signed [VALUE_WIDTH-1:0] swap_val;
      moving = 1'b1;
      while (moving) begin
         top = node;
         for (int kid = 2 * node + 1; kid <= 2 * node + 2; kid++) begin
            if (kid < heap_size && held_values[kid] > held_values[top])
               top = kid;
         end
         if (top == node) begin
            moving = 1'b0;
         end else begin
            swap_val          = held_values[node];
            held_values[node] = held_values[top];
            held_values[top]  = swap_val;
            node              = top;
         end
      end
   endfunction

   task automatic queue_set(int set_len);
      req_type beat;
      for (int n = 0; n < set_len; n++) begin
         case ($urandom_range(7))
            0: beat.value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            1: beat.value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            // Narrow range so that equal values show up often.
            2: beat.value = $signed($urandom_range(15)) - 8;
            default: beat.value = $urandom;
         endcase
         beat.last = (n == set_len - 1);
         pending_items.push_back(beat);
      end
   endtask

   task automatic queue_small_sets(int target);
      int queued;
      int set_len;
      queued = 0;
      while (queued < target) begin
         set_len = $urandom_range(1, 10);
         queue_set(set_len);
         queued += set_len;
      end
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_items.size() != 0 || req_valid || sorted_expect.size() != 0);
   endtask

   // Driver: new beats and stall decisions are applied on the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Long receiver hold-off, counted down here.
   always @(negedge clock) begin
      if (hold_left > 0)
         hold_left <= hold_left - 1;
   end

   // Monitor: predicts on every accepted input beat and checks every result beat.
   always @(posedge clock) begin : monitor
      int k;
      logic signed [VALUE_WIDTH-1:0] swap_val;
      rsp_type want;
      if (reset) begin
         req_taken    <= 1'b0;
         held_count   = 0;
         held_dropped = 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            items_accepted++;
            if (held_count < CAPACITY) begin
               held_values[held_count] = req_data.value;
               held_count++;
            end else begin
               held_dropped = 1'b1;
            end
            if (req_data.last) begin
               for (k = held_count / 2 - 1; k >= 0; k--)
                  sift_heap(held_count, k);
               for (k = held_count - 1; k > 0; k--) begin
                  swap_val       = held_values[0];
                  held_values[0] = held_values[k];
                  held_values[k] = swap_val;
                  sift_heap(k, 0);
               end
               for (k = 0; k < held_count; k++) begin
                  want.sorted_value = held_values[k];
                  want.final_res    = (k == held_count - 1);
                  want.overflowed   = held_dropped;
                  sorted_expect.push_back(want);
               end
               sets_closed++;
               if (held_dropped)
                  overflow_sets++;
               held_count   = 0;
               held_dropped = 1'b0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (sorted_expect.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result beat with nothing expected: value %0d final %b ovf %b",
                           rsp_data.sorted_value, rsp_data.final_res, rsp_data.overflowed);
            end else begin
               want = sorted_expect.pop_front();
               results_checked++;
               if (rsp_data.sorted_value !== want.sorted_value ||
                   rsp_data.final_res !== want.final_res ||
                   rsp_data.overflowed !== want.overflowed) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected value %0d final %b ovf %b, got %0d %b %b",
                              want.sorted_value, want.final_res, want.overflowed,
                              rsp_data.sorted_value, rsp_data.final_res,
                              rsp_data.overflowed);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      req_type beat;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // No idling: single-value sets, extremes, duplicates, then a full store.
      // The receiver is held off so the block backs up and stalls its input.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int n = 0; n < 20; n++) begin
         beat.value = directed_values[n];
         beat.last  = directed_last[n];
         pending_items.push_back(beat);
      end
      queue_set(CAPACITY);
      queue_small_sets(8);
      hold_left = 600;
      wait_drained();

      // Sparse sender.
      send_idle_pct = 81;
      queue_small_sets(15);
      wait_drained();

      // Receiver stalls heavily; one set whose last beat is dropped.
      send_idle_pct  = 0;
      recv_stall_pct = 81;
      queue_set(CAPACITY + 1);
      queue_small_sets(5);
      wait_drained();

      // Both sides idle; a set that overflows by several beats.
      send_idle_pct  = 27;
      recv_stall_pct = 27;
      queue_set(CAPACITY + 6);
      queue_small_sets(5);
      queue_set(1);
      wait_drained();

      repeat (300) @(posedge clock);
      mismatch_count += sorted_expect.size();

      $display("sorted %0d sets from %0d input beats, %0d of them overflowing the store",
               sets_closed, items_accepted, overflow_sets);
      $display("checked %0d result beats, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
